// ----- hdl/assert_macros.svh -----
// Assertion macros used by the chained hash table core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ----- hdl/cht_pkg.sv -----
// Types, constants and elaboration-time helpers of the chained hash table.
package cht_pkg;

  localparam int KEY_W      = 31;
  localparam int ACT_W      = 2;
  localparam int OUT_BKT_W  = 3;
  localparam int NUM_DIGITS = 4;
  localparam int DIGIT_W    = 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_SEARCH = 2'd2
  } action_t;

  typedef struct packed {
    action_t            action;
    logic [KEY_W-1:0]   key;
  } req_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_READ,
    ST_EXEC
  } back_state_t;

  typedef struct packed {
    logic clearing;
    logic exec;
  } back_stat_t;

  // Remainder of a constant by a constant, one bit per step; only ever
  // evaluated on constants while building the residue tables.
  function automatic logic [10:0] const_mod(input logic [31:0] x, input int unsigned b);
    logic [11:0] r;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      r = {r[10:0], x[i]};
      if (r >= 12'(b)) begin
        r = r - 12'(b);
      end
    end
    return r[10:0];
  endfunction

endpackage

// ----- hdl/cht_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic [WIDTH-1:0]        wdata,
  input  logic                    re,
  input  logic [AW-1:0]           raddr,
  output logic [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- hdl/cht_front.sv -----
// Front end: takes requests and works out the bucket from the key.
module cht_front
  import cht_pkg::*;
#(
  parameter int BUCKETS = 7,
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           hold,
  input  logic           in_valid,
  output logic           in_ready,
  input  req_t           in_req,
  input  logic           q_full,
  output logic           q_push,
  output req_t           q_req,
  output logic [BW-1:0]  q_bucket
);
  localparam int SW = BW + 2;

  // Residue tables: entry d of table j is (d * 2^(8j)) mod BUCKETS.
  logic [BW-1:0] res_tab [NUM_DIGITS][1 << DIGIT_W];

  for (genvar j = 0; j < NUM_DIGITS; j++) begin : g_tab
    for (genvar d = 0; d < (1 << DIGIT_W); d++) begin : g_ent
      assign res_tab[j][d] = BW'(const_mod(32'(d) << (DIGIT_W * j), BUCKETS));
    end
  end

  logic                    s1_valid_r;
  req_t                    s1_req_r;
  logic [BW-1:0]           s1_res_r [NUM_DIGITS];
  logic [NUM_DIGITS*DIGIT_W-1:0] key_ext;
  logic [SW-1:0]           sum;
  logic [SW-1:0]           red;
  logic                    take;

  assign key_ext  = (NUM_DIGITS*DIGIT_W)'(in_req.key);
  assign in_ready = !hold && (!s1_valid_r || !q_full);
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (take) begin
      s1_valid_r <= 1'b1;
    end else if (!q_full) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_req_r <= in_req;
      for (int j = 0; j < NUM_DIGITS; j++) begin
        s1_res_r[j] <= res_tab[j][key_ext[DIGIT_W*j +: DIGIT_W]];
      end
    end
  end

  // The four residues sum to less than four times the bucket count.
  always_comb begin
    sum = '0;
    for (int j = 0; j < NUM_DIGITS; j++) begin
      sum = sum + SW'(s1_res_r[j]);
    end
    red = sum;
    if (red >= SW'(2 * BUCKETS)) begin
      red = red - SW'(2 * BUCKETS);
    end
    if (red >= SW'(BUCKETS)) begin
      red = red - SW'(BUCKETS);
    end
  end

  assign q_push   = s1_valid_r && !q_full;
  assign q_req    = s1_req_r;
  assign q_bucket = red[BW-1:0];
endmodule

// ----- hdl/cht_fifo.sv -----
// Two-entry queue between the front end and the back end.
module cht_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] ent_r [2];
  logic             wptr_r;
  logic             rptr_r;
  logic [1:0]       count_r;

  assign full  = (count_r == 2'd2);
  assign valid = (count_r != 2'd0);
  assign rdata = ent_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= !wptr_r;
      end
      if (pop) begin
        rptr_r <= !rptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= wdata;
    end
  end
endmodule

// ----- hdl/cht_back.sv -----
// Back end: read-modify-write of one bucket row per request, and the result register.
module cht_back
  import cht_pkg::*;
#(
  parameter int BUCKETS          = 7,
  parameter int SLOTS_PER_BUCKET = 4,
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  req_t                 q_req,
  input  logic [BW-1:0]        q_bucket,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit,
  output logic                 out_overflow,
  output logic [OUT_BKT_W-1:0] out_bucket,
  output back_stat_t           stat
);
  localparam int FW    = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int IW    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int ROW_W = SLOTS_PER_BUCKET * KEY_W + FW;

  back_state_t           state_r, state_nxt;
  logic [BW-1:0]         clr_idx_r, clr_idx_nxt;
  req_t                  cur_req_r;
  logic [BW-1:0]         cur_bucket_r;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_hit_r;
  logic                  out_ovf_r;
  logic [OUT_BKT_W-1:0]  out_bucket_r;

  logic                  ram_we;
  logic [BW-1:0]         ram_waddr;
  logic [ROW_W-1:0]      ram_wdata;
  logic [ROW_W-1:0]      ram_rdata;

  logic [FW-1:0]         fill;
  logic [KEY_W-1:0]      keys     [SLOTS_PER_BUCKET];
  logic [KEY_W-1:0]      new_keys [SLOTS_PER_BUCKET];
  logic [ROW_W-FW-1:0]   new_slots;
  logic [FW-1:0]         new_fill;
  logic [SLOTS_PER_BUCKET-1:0] match;
  logic [IW-1:0]         pos;
  logic                  found;
  logic                  full_b;
  logic                  upd;
  logic                  res_hit;
  logic                  res_ovf;
  logic                  exec;

  cht_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (q_pop),
    .raddr (q_bucket),
    .rdata (ram_rdata)
  );

  // Row layout: slot 0 in the lowest bits, fill count on top.
  always_comb begin
    fill = ram_rdata[ROW_W-1 -: FW];
    for (int i = 0; i < SLOTS_PER_BUCKET; i++) begin
      keys[i]  = ram_rdata[i*KEY_W +: KEY_W];
      match[i] = (FW'(i) < fill) && (keys[i] == cur_req_r.key);
    end
    found = |match;
    pos   = '0;
    for (int i = SLOTS_PER_BUCKET - 1; i >= 0; i--) begin
      if (match[i]) begin
        pos = IW'(i);
      end
    end
    full_b = (fill >= FW'(SLOTS_PER_BUCKET));
  end

  always_comb begin
    new_fill = fill;
    res_hit  = 1'b0;
    res_ovf  = 1'b0;
    upd      = 1'b0;
    for (int i = 0; i < SLOTS_PER_BUCKET; i++) begin
      new_keys[i] = keys[i];
    end
    case (cur_req_r.action)
      ACT_INSERT: begin
        if (full_b) begin
          res_ovf = 1'b1;
        end else begin
          res_hit  = 1'b1;
          upd      = 1'b1;
          new_fill = fill + FW'(1);
          for (int i = 0; i < SLOTS_PER_BUCKET; i++) begin
            if (FW'(i) == fill) begin
              new_keys[i] = cur_req_r.key;
            end
          end
        end
      end
      ACT_DELETE: begin
        if (found) begin
          res_hit  = 1'b1;
          upd      = 1'b1;
          new_fill = fill - FW'(1);
          // Later entries move down one slot, keeping their order.
          for (int i = 0; i < SLOTS_PER_BUCKET - 1; i++) begin
            if (IW'(i) >= pos) begin
              new_keys[i] = keys[i + 1];
            end
          end
        end
      end
      ACT_SEARCH: begin
        res_hit = found;
      end
      default: begin
        res_hit = 1'b0;
      end
    endcase
    for (int i = 0; i < SLOTS_PER_BUCKET; i++) begin
      new_slots[i*KEY_W +: KEY_W] = new_keys[i];
    end
  end

  assign exec = (state_r == ST_EXEC);

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = cur_bucket_r;
    ram_wdata     = {new_fill, new_slots};
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_r;
        ram_wdata = {FW'(0), (ROW_W-FW)'(0)};
        if (clr_idx_r == BW'(BUCKETS - 1)) begin
          state_nxt = ST_READ;
        end else begin
          clr_idx_nxt = clr_idx_r + BW'(1);
        end
      end
      ST_READ: begin
        if (q_valid && (!out_valid_r || out_ready)) begin
          q_pop     = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ram_we        = upd;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_READ;
      end
      default: begin
        state_nxt = ST_READ;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_req_r    <= q_req;
      cur_bucket_r <= q_bucket;
    end
    if (exec) begin
      out_hit_r    <= res_hit;
      out_ovf_r    <= res_ovf;
      out_bucket_r <= OUT_BKT_W'(cur_bucket_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_overflow  = out_ovf_r;
  assign out_bucket    = out_bucket_r;
  assign stat.clearing = (state_r == ST_CLEAR);
  assign stat.exec     = exec;
endmodule

// ----- hdl/chained_hash_table_core.sv -----
// Top level of the chained hash table: front end, request queue and back end.
//
//  Channel | Direction | Ports                          | Contents
//  --------+-----------+--------------------------------+-----------------------------
//  in      | input     | in_tvalid, in_tready, in_tdata | one request: action, key
//  out     | output    | out_tvalid, out_tready, ...    | one result: hit, overflow,
//          |           |   out_tdata                    |   bucket
//
// The back end handles one request at a time: ST_READ pops it and reads the bucket row, then
// ST_EXEC updates the row, writes it back and loads the result register.
// A request is registered in the front end while its bucket is formed from residue tables,
// then waits in a two-entry queue until the back end pops it.
// After reset a clearing pass zeroes every bucket row, one per cycle.
// A stalled result holds the back end while the front end keeps taking until the queue fills.
`include "assert_macros.svh"

module chained_hash_table_core
  import cht_pkg::*;
#(
  parameter int BUCKETS          = 7,
  parameter int SLOTS_PER_BUCKET = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [1:0] action, [32:2] key, [39:33] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [0] hit, [1] overflow, [4:2] bucket, [7:5] zero
);
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int QW = $bits(req_t) + BW;

  req_t                  in_req;
  logic                  q_full;
  logic                  q_push;
  req_t                  f_req;
  logic [BW-1:0]         f_bucket;
  logic                  q_pop;
  logic                  q_valid;
  logic [QW-1:0]         q_rdata;
  req_t                  q_req;
  logic [BW-1:0]         q_bucket;
  logic                  res_hit;
  logic                  res_ovf;
  logic [OUT_BKT_W-1:0]  res_bucket;
  back_stat_t            stat;

  // Unused action code three passes through unchanged; the back end leaves the bucket as it is and reports no hit.
  assign in_req.action = action_t'(in_tdata[ACT_W-1:0]);
  assign in_req.key    = in_tdata[ACT_W +: KEY_W];

  cht_front #(
    .BUCKETS (BUCKETS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .hold     (stat.clearing),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_req   (in_req),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_req    (f_req),
    .q_bucket (f_bucket)
  );

  cht_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata ({f_req, f_bucket}),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  assign q_req    = q_rdata[QW-1 -: $bits(req_t)];
  assign q_bucket = q_rdata[BW-1:0];

  cht_back #(
    .BUCKETS          (BUCKETS),
    .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_req        (q_req),
    .q_bucket     (q_bucket),
    .q_pop        (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_hit      (res_hit),
    .out_overflow (res_ovf),
    .out_bucket   (res_bucket),
    .stat         (stat)
  );

  assign out_tdata = {3'b000, res_bucket, res_ovf, res_hit};

  // No request may enter while the fill counts are being cleared.
  `ASSERT_IMP(a_no_take_clear, clk, rst_n, stat.clearing, !in_tready)
  // The result register is always free when an update completes.
  `ASSERT_IMP(a_out_free_exec, clk, rst_n, stat.exec, !out_tvalid)
  // The back end only pops a queue entry that is present.
  `ASSERT_IMP(a_pop_valid, clk, rst_n, q_pop, q_valid)
  // Every update is followed by a result on the next cycle.
  `ASSERT_NEXT(a_exec_result, clk, rst_n, stat.exec, out_tvalid)
endmodule
